>>> hdl/rne_pkg.sv
// Shared types, constants and lookup functions of the Roman numeral encoder.
// Depends on nothing; used by the controller, the datapath and the top level.
package rne_pkg;

  localparam int VALUE_W   = 12;
  localparam int CHAR_W    = 8;
  localparam int BCD_W     = 16;
  localparam int CONV_STEPS = 12;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

  // Letter roles inside one decimal digit's pattern.
  localparam logic [1:0] KIND_ONE  = 2'd0;
  localparam logic [1:0] KIND_FIVE = 2'd1;
  localparam logic [1:0] KIND_TEN  = 2'd2;

  // Digit positions, most significant first.
  localparam logic [1:0] POS_THOU = 2'd0;
  localparam logic [1:0] POS_HUND = 2'd1;
  localparam logic [1:0] POS_TENS = 2'd2;
  localparam logic [1:0] POS_UNIT = 2'd3;

  localparam logic [CHAR_W-1:0] CH_M = 8'h4D;
  localparam logic [CHAR_W-1:0] CH_D = 8'h44;
  localparam logic [CHAR_W-1:0] CH_C = 8'h43;
  localparam logic [CHAR_W-1:0] CH_L = 8'h4C;
  localparam logic [CHAR_W-1:0] CH_X = 8'h58;
  localparam logic [CHAR_W-1:0] CH_V = 8'h56;
  localparam logic [CHAR_W-1:0] CH_I = 8'h49;
  localparam logic [CHAR_W-1:0] CH_NONE = 8'h00;

  typedef struct packed {
    logic load;      // capture a new value
    logic shift;     // one binary-to-BCD step
    logic emit_bad;  // send the single invalid beat
    logic emit;      // send the next letter or skip an empty digit
  } cmd_t;

  typedef struct packed {
    logic range_bad; // input value outside 1 to 3999
    logic run_done;  // the letter sent this cycle ends the run
  } sts_t;

  // Number of letters a decimal digit takes.
  function automatic logic [2:0] digit_len(input logic [3:0] d);
    logic [2:0] n;
    case (d)
      4'd0: n = 3'd0;
      4'd1: n = 3'd1;
      4'd2: n = 3'd2;
      4'd3: n = 3'd3;
      4'd4: n = 3'd2;
      4'd5: n = 3'd1;
      4'd6: n = 3'd2;
      4'd7: n = 3'd3;
      4'd8: n = 3'd4;
      4'd9: n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Role of the letter at a given step of a digit's pattern.
  function automatic logic [1:0] digit_kind(input logic [3:0] d, input logic [1:0] s);
    logic [1:0] k;
    k = KIND_ONE;
    case (d)
      4'd4: k = (s == 2'd1) ? KIND_FIVE : KIND_ONE;
      4'd9: k = (s == 2'd1) ? KIND_TEN : KIND_ONE;
      4'd5, 4'd6, 4'd7, 4'd8: k = (s == 2'd0) ? KIND_FIVE : KIND_ONE;
      default: k = KIND_ONE;
    endcase
    return k;
  endfunction

endpackage

>>> hdl/roman_numeral_encoder.sv
// Top level of the Roman numeral encoder: joins controller and datapath.
// Depends on rne_pkg, rne_ctrl and rne_datapath.
//
// Usage. Drive in_value and raise start; the number is taken at a rising edge
// where start is high and busy is low. The block then sends the Roman numeral
// one ASCII letter per beat on out_character, most significant letter first,
// each beat marked by out_valid for exactly one cycle; out_last flags the final
// beat. A value of 0 or above 3999 gives one beat with character 0, out_last
// and out_invalid set.
// Timing. An out-of-range value passes through the ST_BAD state, where its beat
// is registered; the beat is shown once busy is low again. A valid value first
// goes through the bit-serial binary-to-BCD shifter, then walks its four digits,
// sending one letter per beat and skipping each zero digit that lies ahead of
// the last letter; busy stays high until the last letter has been registered.
// Leading zero digits are skipped before the first letter. A new number may be
// accepted while the last beat of the previous run is still on the output
// register.
// Reset clears the controller and the output strobe; the receiver cannot stall,
// so every beat must be taken in the cycle it is shown.
module roman_numeral_encoder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rne_pkg::VALUE_W-1:0] in_value,
  output logic                        busy,
  output logic                        out_valid,
  output logic [rne_pkg::CHAR_W-1:0]  out_character,
  output logic                        out_last,
  output logic                        out_invalid
);
  import rne_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rne_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  rne_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_value      (in_value),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last      (out_last),
    .out_invalid   (out_invalid)
  );

endmodule

>>> hdl/rne_ctrl.sv
// Controller state machine of the Roman numeral encoder.
// Depends on rne_pkg; drives the datapath through cmd_t and reads sts_t.
module rne_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  rne_pkg::sts_t sts,
  output rne_pkg::cmd_t cmd,
  output logic          busy
);
  import rne_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_CONV = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          cnt_nxt   = 4'd0;
          state_nxt = sts.range_bad ? ST_BAD : ST_CONV;
        end
      end
      ST_BAD: begin
        cmd.emit_bad = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
        cnt_nxt   = cnt_r + 4'd1;
        if (cnt_r == 4'(CONV_STEPS - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.run_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= 4'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

>>> hdl/rne_datapath.sv
// Datapath of the Roman numeral encoder: binary-to-BCD shifter, digit walker,
// letter lookup and output register. Depends on rne_pkg.
module rne_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rne_pkg::cmd_t               cmd,
  input  logic [rne_pkg::VALUE_W-1:0] in_value,
  output rne_pkg::sts_t               sts,
  output logic                        out_valid,
  output logic [rne_pkg::CHAR_W-1:0]  out_character,
  output logic                        out_last,
  output logic                        out_invalid
);
  import rne_pkg::*;

  logic [VALUE_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [BCD_W-1:0]   bcd_adj;
  logic [1:0]         pos_r, pos_nxt;
  logic [1:0]         step_r, step_nxt;
  logic               valid_r, valid_nxt;
  logic [CHAR_W-1:0]  char_r, char_nxt;
  logic               last_r, last_nxt;
  logic               inv_r, inv_nxt;

  logic [3:0]        digit;
  logic              lower_zero;
  logic [2:0]        len;
  logic              step_last;
  logic [1:0]        kind;
  logic [CHAR_W-1:0] letter;

  // Double dabble: correct every nibble of five or more before each shift.
  always_comb begin
    for (int i = 0; i < BCD_W / 4; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3
                                                   : bcd_r[i*4 +: 4];
    end
  end

  always_comb begin
    case (pos_r)
      POS_THOU: begin
        digit      = bcd_r[15:12];
        lower_zero = (bcd_r[11:0] == 12'd0);
      end
      POS_HUND: begin
        digit      = bcd_r[11:8];
        lower_zero = (bcd_r[7:0] == 8'd0);
      end
      POS_TENS: begin
        digit      = bcd_r[7:4];
        lower_zero = (bcd_r[3:0] == 4'd0);
      end
      default: begin
        digit      = bcd_r[3:0];
        lower_zero = 1'b1;
      end
    endcase
  end

  assign len       = digit_len(digit);
  assign step_last = ({1'b0, step_r} == len - 3'd1);
  assign kind      = digit_kind(digit, step_r);

  always_comb begin
    letter = CH_I;
    case (pos_r)
      POS_THOU: letter = CH_M;
      POS_HUND: letter = (kind == KIND_ONE) ? CH_C : (kind == KIND_FIVE) ? CH_D : CH_M;
      POS_TENS: letter = (kind == KIND_ONE) ? CH_X : (kind == KIND_FIVE) ? CH_L : CH_C;
      default:  letter = (kind == KIND_ONE) ? CH_I : (kind == KIND_FIVE) ? CH_V : CH_X;
    endcase
  end

  assign sts.range_bad = (in_value == '0) || (in_value > VALUE_MAX);
  assign sts.run_done  = (len != 3'd0) && step_last && lower_zero;

  always_comb begin
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    pos_nxt   = pos_r;
    step_nxt  = step_r;
    valid_nxt = 1'b0;
    char_nxt  = char_r;
    last_nxt  = last_r;
    inv_nxt   = inv_r;
    if (cmd.load) begin
      bin_nxt  = in_value;
      bcd_nxt  = '0;
      pos_nxt  = POS_THOU;
      step_nxt = 2'd0;
    end
    if (cmd.shift) begin
      {bcd_nxt, bin_nxt} = {bcd_adj[BCD_W-2:0], bin_r, 1'b0};
    end
    if (cmd.emit_bad) begin
      valid_nxt = 1'b1;
      char_nxt  = CH_NONE;
      last_nxt  = 1'b1;
      inv_nxt   = 1'b1;
    end
    if (cmd.emit) begin
      if (len == 3'd0) begin
        // Zero digit: nothing to send, move on to the next position.
        pos_nxt  = pos_r + 2'd1;
        step_nxt = 2'd0;
      end else begin
        valid_nxt = 1'b1;
        char_nxt  = letter;
        last_nxt  = sts.run_done;
        inv_nxt   = 1'b0;
        if (step_last) begin
          pos_nxt  = pos_r + 2'd1;
          step_nxt = 2'd0;
        end else begin
          step_nxt = step_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
    pos_r  <= pos_nxt;
    step_r <= step_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
    inv_r  <= inv_nxt;
  end

  assign out_valid     = valid_r;
  assign out_character = char_r;
  assign out_last      = last_r;
  assign out_invalid   = inv_r;

endmodule

>>> bench/rne_checker.sv
// Checker for the Roman numeral encoder: predicts the letter beats of every
// accepted number and compares them with the beats the block sends.
// Depends on rne_pkg for widths and the ASCII letter codes.
module rne_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [rne_pkg::VALUE_W-1:0] in_value,
  input  logic                        out_valid,
  input  logic [rne_pkg::CHAR_W-1:0]  out_character,
  input  logic                        out_last,
  input  logic                        out_invalid,
  output int                          mismatches,
  output int                          pending,
  output int                          beats_checked
);

  typedef struct packed {
    logic [rne_pkg::CHAR_W-1:0] ch;
    logic                       last;
    logic                       invalid;
  } beat_t;

  beat_t                      expected_beats[$];
  logic [rne_pkg::CHAR_W-1:0] numeral_letters[$];
  int                         error_count = 0;
  int                         beat_count = 0;

  // One decimal digit in its subtractive pattern; a zero digit adds nothing.
  function automatic void spell_digit(input int digit, input logic [7:0] one,
                                      input logic [7:0] five, input logic [7:0] ten);
    int d;
    int k;
    d = digit;
    if (d == 9) begin
      numeral_letters.push_back(one);
      numeral_letters.push_back(ten);
    end else if (d == 4) begin
      numeral_letters.push_back(one);
      numeral_letters.push_back(five);
    end else begin
      if (d >= 5) begin
        numeral_letters.push_back(five);
        d = d - 5;
      end
      for (k = 0; k < d; k++)
        numeral_letters.push_back(one);
    end
  endfunction

  function automatic void predict_numeral(input logic [rne_pkg::VALUE_W-1:0] value);
    beat_t b;
    int    v;
    int    i;
    v = value;
    if (v < 1 || v > rne_pkg::VALUE_MAX) begin
      b.ch      = rne_pkg::CH_NONE;
      b.last    = 1'b1;
      b.invalid = 1'b1;
      expected_beats.push_back(b);
    end else begin
      numeral_letters.delete();
      for (i = 0; i < v / 1000; i++)
        numeral_letters.push_back(rne_pkg::CH_M);
      spell_digit((v % 1000) / 100, rne_pkg::CH_C, rne_pkg::CH_D, rne_pkg::CH_M);
      spell_digit((v % 100) / 10, rne_pkg::CH_X, rne_pkg::CH_L, rne_pkg::CH_C);
      spell_digit(v % 10, rne_pkg::CH_I, rne_pkg::CH_V, rne_pkg::CH_X);
      for (i = 0; i < numeral_letters.size(); i++) begin
        b.ch      = numeral_letters[i];
        b.last    = (i == numeral_letters.size() - 1);
        b.invalid = 1'b0;
        expected_beats.push_back(b);
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    beat_t want;
    if (rst_n) begin
      // A beat shown now always belongs to an earlier number, so the order of
      // these two steps does not matter.
      if (out_valid) begin
        beat_count++;
        if (expected_beats.size() == 0) begin
          error_count++;
          $display("%0t checker: expected no beat, got char %h last %b invalid %b",
                   $time, out_character, out_last, out_invalid);
        end else begin
          want = expected_beats.pop_front();
          if (out_character !== want.ch || out_last !== want.last ||
              out_invalid !== want.invalid) begin
            error_count++;
            $display("%0t: expected char %h last %b invalid %b, got char %h last %b invalid %b",
                     $time, want.ch, want.last, want.invalid,
                     out_character, out_last, out_invalid);
          end
        end
      end
      if (start && !busy)
        predict_numeral(in_value);
    end
    mismatches    <= error_count;
    pending       <= expected_beats.size();
    beats_checked <= beat_count;
  end

endmodule

>>> bench/tb_top.sv
// Top of the Roman numeral encoder testbench: clock, reset, number stimulus
// and the verdict. Depends on rne_pkg, roman_numeral_encoder and rne_checker.
module tb_top;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        start;
  logic [rne_pkg::VALUE_W-1:0] in_value;
  logic                        busy;
  logic                        out_valid;
  logic [rne_pkg::CHAR_W-1:0]  out_character;
  logic                        out_last;
  logic                        out_invalid;
  int                          mismatches;
  int                          pending;
  int                          beats_checked;
  int                          numbers_sent = 0;
  int                          out_of_range = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  roman_numeral_encoder DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .in_value(in_value), .busy(busy),
    .out_valid(out_valid), .out_character(out_character), .out_last(out_last),
    .out_invalid(out_invalid)
  );

  rne_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_value(in_value),
    .out_valid(out_valid), .out_character(out_character), .out_last(out_last),
    .out_invalid(out_invalid), .mismatches(mismatches), .pending(pending),
    .beats_checked(beats_checked)
  );

  // Returns at the edge where the number was taken, with start still high.
  task automatic send_number(input logic [rne_pkg::VALUE_W-1:0] v);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    numbers_sent++;
    if (v == 0 || v > rne_pkg::VALUE_MAX)
      out_of_range++;
  endtask

  // Mostly legal numbers, many built digit by digit so zero digits are common.
  function automatic logic [rne_pkg::VALUE_W-1:0] pick_number();
    int sel;
    int v;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      v = $urandom_range(4000, 4095);
    end else if (sel < 11) begin
      v = 0;
    end else if (sel < 50) begin
      v = $urandom_range(0, 3) * 1000;
      v += ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9) * 100;
      v += ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9) * 10;
      v += ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
      if (v == 0)
        v = 1;
    end else begin
      v = $urandom_range(1, 3999);
    end
    return v[rne_pkg::VALUE_W-1:0];
  endfunction

  logic [rne_pkg::VALUE_W-1:0] directed_numbers[] = '{
    12'd0, 12'd1, 12'd3999, 12'd4000, 12'd4095, 12'd3888, 12'd4, 12'd9,
    12'd40, 12'd90, 12'd400, 12'd900, 12'd1000, 12'd3000, 12'd5, 12'd10,
    12'd50, 12'd100, 12'd500, 12'd1994, 12'd2730, 12'd1365, 12'd3008, 12'd707
  };

  initial begin
    int i;
    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_value <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_numbers[i])
      send_number(directed_numbers[i]);
    for (i = 0; i < 146; i++)
      send_number(pick_number());
    start <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);

    $display("tb: %0d numbers converted, %0d of them out of range, %0d letter beats checked",
             numbers_sent, out_of_range, beats_checked);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

endmodule
